[design/pgalloc_pkg.sv]
`timescale 1ns / 1ps

package pgalloc_pkg;

    localparam int ADDR_W     = 32;
    localparam int EXT_W      = ADDR_W + 1;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PNUM_W     = ADDR_W - PAGE_SHIFT;
    localparam int FREE_DEPTH = 256;
    localparam int IDX_W      = $clog2(FREE_DEPTH);
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_OUT_OF_MEM = 2'd1,
        ST_NULL_FREE  = 2'd2,
        ST_STORE_FULL = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REGION_BASE = 1'b0,
        REG_REGION_SIZE = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic exec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_stall;
    } t_dp_stat;

endpackage

[design/page_allocator_free_stack.sv]
`timescale 1ns / 1ps

// page allocator over one region: allocate pops the most recently freed page
// from a 256-entry lifo store, else hands out the bump pointer one page at a
// time; free pushes a page. one item is in the block at a time; the accepted
// item is registered, the fetch state reads the free store ram into a register,
// then the execute state loads the result register, and only after that is the
// input ready again, so no new item is taken while one is in work. execution
// waits while the previous result is still held on the output; a held result
// does not block acceptance of the next item. the rounded region end is
// registered from the region registers, and the remaining room from it and the
// bump pointer. a config write reloads the bump pointer only; freed pages stay
// in the store. no clearing pass is needed after reset.
module page_allocator_free_stack (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [pgalloc_pkg::ADDR_W-1:0]        i_s_axis_tdata,  // [31:0] page_addr
    input  logic                                  i_s_axis_tuser,  // [0] func
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [31:0] granted_addr, [63:32] free_bytes
    output logic [2*pgalloc_pkg::ADDR_W-1:0]      o_m_axis_tdata,
    output logic [pgalloc_pkg::STATUS_W-1:0]      o_m_axis_tuser,  // [1:0] status
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pgalloc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pgalloc_pkg::ADDR_W-1:0]        i_cfg_data
);

    pgalloc_pkg::t_cmd                  cmd;
    pgalloc_pkg::t_dp_stat              stat;
    logic [pgalloc_pkg::ADDR_W-1:0]     granted_addr;
    logic [pgalloc_pkg::ADDR_W-1:0]     free_bytes;

    assign o_cfg_ready = 1'b1;

    pgalloc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pgalloc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_func         (i_s_axis_tuser),
        .i_page_addr    (i_s_axis_tdata),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_granted_addr (granted_addr),
        .o_status       (o_m_axis_tuser),
        .o_free_bytes   (free_bytes)
    );

    assign o_m_axis_tdata = {free_bytes, granted_addr};

endmodule

[design/pgalloc_ctrl.sv]
`timescale 1ns / 1ps

module pgalloc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pgalloc_pkg::t_dp_stat i_stat,
    output pgalloc_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_FETCH;
                end
            end
            // free store read settles during this cycle
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!i_stat.out_stall) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/pgalloc_dp.sv]
`timescale 1ns / 1ps

module pgalloc_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pgalloc_pkg::t_cmd                     i_cmd,
    output pgalloc_pkg::t_dp_stat                 o_stat,
    input  logic                                  i_func,
    input  logic [pgalloc_pkg::ADDR_W-1:0]        i_page_addr,
    input  logic                                  i_cfg_we,
    input  logic [pgalloc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pgalloc_pkg::ADDR_W-1:0]        i_cfg_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [pgalloc_pkg::ADDR_W-1:0]        o_granted_addr,
    output logic [pgalloc_pkg::STATUS_W-1:0]      o_status,
    output logic [pgalloc_pkg::ADDR_W-1:0]        o_free_bytes
);

    localparam int AW = pgalloc_pkg::ADDR_W;
    localparam int EW = pgalloc_pkg::EXT_W;
    localparam logic [EW-1:0] OFFSET_MASK = EW'(pgalloc_pkg::PAGE_BYTES - 1);
    localparam logic [EW-1:0] PAGE_STEP   = EW'(pgalloc_pkg::PAGE_BYTES);
    localparam logic [EW-1:0] TOP_MEM     = EW'(1) << AW;
    localparam logic [pgalloc_pkg::CNT_W-1:0] CNT_FULL =
        pgalloc_pkg::CNT_W'(pgalloc_pkg::FREE_DEPTH);

    function automatic logic [EW-1:0] round_up(input logic [AW-1:0] a);
        return ({1'b0, a} + OFFSET_MASK) & ~OFFSET_MASK;
    endfunction

    logic [AW-1:0]                     r_base;
    logic [AW-1:0]                     r_size;
    logic [EW-1:0]                     r_end;
    logic [EW-1:0]                     r_bump;
    logic [EW-1:0]                     r_room;
    logic [pgalloc_pkg::CNT_W-1:0]     r_count;
    logic [pgalloc_pkg::PNUM_W-1:0]    r_mem [pgalloc_pkg::FREE_DEPTH];
    logic [pgalloc_pkg::PNUM_W-1:0]    r_rd_data;
    logic                              r_func;
    logic [AW-1:0]                     r_page_addr;
    logic                              r_out_valid;
    logic [AW-1:0]                     r_granted;
    logic [pgalloc_pkg::STATUS_W-1:0]  r_status;
    logic [AW-1:0]                     r_free;

    logic [EW-1:0]                     n_end_raw;
    logic [EW-1:0]                     n_end;
    logic [pgalloc_pkg::IDX_W-1:0]     rd_idx;
    logic                              do_pop;
    logic                              do_bump;
    logic                              do_push;
    logic [EW-1:0]                     room_after;
    logic [AW-1:0]                     n_granted;
    pgalloc_pkg::t_status              n_status;

    assign n_end_raw = ({1'b0, r_base} + {1'b0, r_size}) & ~OFFSET_MASK;
    assign n_end     = (n_end_raw > TOP_MEM) ? TOP_MEM : n_end_raw;
    // top of stack; wraps to the last entry when the store is full
    assign rd_idx    = r_count[pgalloc_pkg::IDX_W-1:0] - pgalloc_pkg::IDX_W'(1);

    assign do_pop  = (r_func == pgalloc_pkg::FUNC_ALLOC) && (r_count != '0);
    assign do_bump = (r_func == pgalloc_pkg::FUNC_ALLOC) && (r_count == '0)
                     && (r_room >= PAGE_STEP);
    assign do_push = (r_func == pgalloc_pkg::FUNC_FREE) && (r_page_addr != '0)
                     && (r_count != CNT_FULL);

    assign room_after = do_bump ? (r_room - PAGE_STEP) : r_room;

    always_comb begin
        n_granted = '0;
        n_status  = pgalloc_pkg::ST_OK;
        if (r_func == pgalloc_pkg::FUNC_ALLOC) begin
            if (do_pop) begin
                n_granted = {r_rd_data, pgalloc_pkg::PAGE_SHIFT'(0)};
            end else if (do_bump) begin
                n_granted = r_bump[AW-1:0];
            end else begin
                n_status = pgalloc_pkg::ST_OUT_OF_MEM;
            end
        end else begin
            if (r_page_addr == '0) begin
                n_status = pgalloc_pkg::ST_NULL_FREE;
            end else if (r_count == CNT_FULL) begin
                n_status = pgalloc_pkg::ST_STORE_FULL;
            end
        end
    end

    // region registers and derived bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_size <= '0;
            r_end  <= '0;
            r_bump <= '0;
            r_room <= '0;
        end else begin
            r_end  <= n_end;
            r_room <= (r_bump < r_end) ? (r_end - r_bump) : '0;
            if (i_cfg_we) begin
                unique case (pgalloc_pkg::t_cfg_reg'(i_cfg_index))
                    pgalloc_pkg::REG_REGION_BASE: begin
                        r_base <= i_cfg_data;
                        r_bump <= round_up(i_cfg_data);
                    end
                    pgalloc_pkg::REG_REGION_SIZE: begin
                        r_size <= i_cfg_data;
                        r_bump <= round_up(r_base);
                    end
                    default: begin
                        r_bump <= r_bump;
                    end
                endcase
            end else if (i_cmd.exec && do_bump) begin
                r_bump <= r_bump + PAGE_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (do_pop) begin
                r_count <= r_count - pgalloc_pkg::CNT_W'(1);
            end else if (do_push) begin
                r_count <= r_count + pgalloc_pkg::CNT_W'(1);
            end
        end
    end

    // free store ram
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_push) begin
            r_mem[r_count[pgalloc_pkg::IDX_W-1:0]] <=
                r_page_addr[AW-1:pgalloc_pkg::PAGE_SHIFT];
        end
        r_rd_data <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func      <= i_func;
            r_page_addr <= i_page_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_granted <= n_granted;
            r_status  <= n_status;
            r_free    <= room_after[AW] ? '1 : room_after[AW-1:0];
        end
    end

    assign o_stat.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_granted_addr   = r_granted;
    assign o_status         = r_status;
    assign o_free_bytes     = r_free;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int ADDR_W     = pgalloc_pkg::ADDR_W;
    localparam int PAGE_BYTES = pgalloc_pkg::PAGE_BYTES;
    localparam int PAGE_SHIFT = pgalloc_pkg::PAGE_SHIFT;
    localparam int PNUM_W     = pgalloc_pkg::PNUM_W;
    localparam int FREE_DEPTH = pgalloc_pkg::FREE_DEPTH;
    localparam int STATUS_W   = pgalloc_pkg::STATUS_W;
    localparam int CFG_IDX_W  = pgalloc_pkg::CFG_IDX_W;

    localparam logic [33:0] OFFSET_MASK   = 34'(PAGE_BYTES - 1);
    localparam logic [33:0] TOP_OF_MEMORY = 34'h1_0000_0000;

    typedef struct {
        logic [ADDR_W-1:0]    grant;
        pgalloc_pkg::t_status status;
        logic [ADDR_W-1:0]    room;
    } t_page_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [ADDR_W-1:0]         i_s_axis_tdata;
    logic                      i_s_axis_tuser;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    logic [2*ADDR_W-1:0]       o_m_axis_tdata;
    logic [STATUS_W-1:0]       o_m_axis_tuser;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [ADDR_W-1:0]         i_cfg_data;

    // shadow copy of the allocator state
    logic [ADDR_W-1:0]         shadow_base;
    logic [ADDR_W-1:0]         shadow_size;
    logic [33:0]               shadow_bump;
    logic [PNUM_W-1:0]         shadow_stack [FREE_DEPTH];
    int                        shadow_count;

    t_page_result              pending_results [$];
    int                        mismatches;
    bit                        quiet_links;

    page_allocator_free_stack u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [33:0] region_start();
        return ({2'b00, shadow_base} + OFFSET_MASK) & ~OFFSET_MASK;
    endfunction

    function automatic logic [33:0] region_end();
        logic [33:0] e;
        e = ({2'b00, shadow_base} + {2'b00, shadow_size}) & ~OFFSET_MASK;
        return (e > TOP_OF_MEMORY) ? TOP_OF_MEMORY : e;
    endfunction

    function automatic logic [ADDR_W-1:0] room_left();
        logic [33:0] e;
        logic [33:0] r;
        e = region_end();
        if (shadow_bump >= e)
            return '0;
        r = e - shadow_bump;
        return (r > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : r[ADDR_W-1:0];
    endfunction

    task automatic predict_page_result(pgalloc_pkg::t_func f, logic [ADDR_W-1:0] addr);
        t_page_result res;
        res.grant  = '0;
        res.status = pgalloc_pkg::ST_OK;
        if (f == pgalloc_pkg::FUNC_ALLOC) begin
            if (shadow_count > 0) begin
                shadow_count--;
                res.grant = ADDR_W'(shadow_stack[shadow_count]) << PAGE_SHIFT;
            end else if (shadow_bump + 34'(PAGE_BYTES) <= region_end()) begin
                res.grant   = shadow_bump[ADDR_W-1:0];
                shadow_bump = shadow_bump + 34'(PAGE_BYTES);
            end else begin
                res.status = pgalloc_pkg::ST_OUT_OF_MEM;
            end
        end else begin
            if (addr == '0) begin
                res.status = pgalloc_pkg::ST_NULL_FREE;
            end else if (shadow_count >= FREE_DEPTH) begin
                res.status = pgalloc_pkg::ST_STORE_FULL;
            end else begin
                // only the page number is kept, low bits are lost
                shadow_stack[shadow_count] = addr[ADDR_W-1:PAGE_SHIFT];
                shadow_count++;
            end
        end
        res.room = room_left();
        pending_results.push_back(res);
    endtask

    task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                   logic [ADDR_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic check_result(logic [ADDR_W-1:0] grant, logic [STATUS_W-1:0] st,
                                logic [ADDR_W-1:0] room);
        t_page_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("item with nothing pending", grant, '0);
            return;
        end
        want = pending_results.pop_front();
        if (grant !== want.grant)
            report_mismatch("granted_addr", grant, want.grant);
        if (st !== want.status)
            report_mismatch("status", ADDR_W'(st), ADDR_W'(want.status));
        if (room !== want.room)
            report_mismatch("free_bytes", room, want.room);
    endtask

    // result side: random stall before each item
    initial begin : result_sink
        int stall;
        i_m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            stall = quiet_links ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            check_result(o_m_axis_tdata[ADDR_W-1:0], o_m_axis_tuser,
                         o_m_axis_tdata[2*ADDR_W-1:ADDR_W]);
        end
    end

    task automatic send_item(pgalloc_pkg::t_func f, logic [ADDR_W-1:0] addr);
        int gap;
        gap = quiet_links ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= addr;
        i_s_axis_tuser  <= f;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        predict_page_result(f, addr);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(pgalloc_pkg::t_cfg_reg idx, logic [ADDR_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == pgalloc_pkg::REG_REGION_BASE)
            shadow_base = val;
        else
            shadow_size = val;
        shadow_bump = region_start();
    endtask

    // which: 0 both registers, 1 base only, 2 size only
    task automatic set_region(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size, int which);
        wait_drained();
        if (which != 2)
            write_reg(pgalloc_pkg::REG_REGION_BASE, base);
        if (which != 1)
            write_reg(pgalloc_pkg::REG_REGION_SIZE, size);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] rand_page_addr();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
            default: return ADDR_W'($urandom);
        endcase
    endfunction

    // empty region straight out of reset
    task automatic test_reset_region();
        send_item(pgalloc_pkg::FUNC_ALLOC, '0);
        send_item(pgalloc_pkg::FUNC_FREE, '0);
        send_item(pgalloc_pkg::FUNC_FREE, 32'hFFFF_FFFF);
        send_item(pgalloc_pkg::FUNC_ALLOC, '0);
    endtask

    task automatic test_region_edges();
        // end clamped at top of memory, two pages then out of memory
        set_region(32'hFFFF_E000, 32'hFFFF_FFFF, 0);
        repeat (3) send_item(pgalloc_pkg::FUNC_ALLOC, '0);
        send_item(pgalloc_pkg::FUNC_FREE, 32'h1234_5678);
        send_item(pgalloc_pkg::FUNC_ALLOC, '0);
        // region holding page zero
        set_region(32'h0000_0000, 32'h0000_3FFF, 0);
        repeat (4) send_item(pgalloc_pkg::FUNC_ALLOC, '0);
        // base rounds past the end
        set_region(32'h0000_5001, 32'h0000_0010, 0);
        send_item(pgalloc_pkg::FUNC_ALLOC, '0);
        send_item(pgalloc_pkg::FUNC_FREE, 32'h0000_0001);
        send_item(pgalloc_pkg::FUNC_ALLOC, '0);
        set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_item(pgalloc_pkg::FUNC_ALLOC, '0);
        set_region(32'h0000_0001, 32'hFFFF_FFFF, 0);
        send_item(pgalloc_pkg::FUNC_ALLOC, '0);
        // freed pages survive a reconfiguration
        send_item(pgalloc_pkg::FUNC_FREE, 32'hABCD_E000);
        set_region(32'h0000_0000, 32'hFFFF_FFFF, 0);
        send_item(pgalloc_pkg::FUNC_ALLOC, '0);
        send_item(pgalloc_pkg::FUNC_ALLOC, '0);
    endtask

    task automatic test_store_overflow();
        logic [ADDR_W-1:0] a;
        set_region(ADDR_W'($urandom), ADDR_W'($urandom_range(1, 8) * PAGE_BYTES), 0);
        repeat (FREE_DEPTH + 8) begin
            a = ADDR_W'($urandom);
            if (a == '0)
                a = 32'h0000_1000;
            send_item(pgalloc_pkg::FUNC_FREE, a);
        end
        repeat (FREE_DEPTH + 12) send_item(pgalloc_pkg::FUNC_ALLOC, '0);
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  size;
        int                 alloc_pct;
        pgalloc_pkg::t_func f;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 4))
                0: begin
                    base = ADDR_W'($urandom);
                    size = ADDR_W'($urandom_range(0, 48) * PAGE_BYTES
                                   + $urandom_range(0, PAGE_BYTES - 1));
                end
                1: begin
                    base = ADDR_W'($urandom);
                    size = ADDR_W'($urandom);
                end
                2: begin
                    base = 32'hFFFF_FFFF - ADDR_W'($urandom_range(0, 8 * PAGE_BYTES));
                    size = ADDR_W'($urandom);
                end
                3: begin
                    base = '0;
                    size = 32'hFFFF_FFFF;
                end
                default: begin
                    base = ADDR_W'($urandom);
                    size = '0;
                end
            endcase
            set_region(base, size, (phase == 0) ? 0 : $urandom_range(0, 2));
            quiet_links = ($urandom_range(0, 3) == 0);
            alloc_pct   = $urandom_range(25, 75);
            for (int n = 0; n < 180; n++) begin
                if (n == 90 && phase == 2)
                    wait_drained();
                f = ($urandom_range(0, 99) < alloc_pct) ? pgalloc_pkg::FUNC_ALLOC
                                                         : pgalloc_pkg::FUNC_FREE;
                send_item(f, (f == pgalloc_pkg::FUNC_FREE) ? rand_page_addr()
                                                           : ADDR_W'($urandom));
            end
        end
        quiet_links = 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        shadow_base  = '0;
        shadow_size  = '0;
        shadow_count = 0;
        shadow_bump  = '0;
        mismatches   = 0;
        quiet_links  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_region();
        test_region_edges();
        test_store_overflow();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
